@@ sv/opc_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// opc_pkg
// Shared widths, constants and types of the online perceptron classifier.
// ============================================================================
package opc_pkg;

    localparam int NUM_WEIGHTS_DEF  = 8;
    localparam int FEATURE_BITS_DEF = 16;
    localparam int MAX_FEATURES     = 8;

    localparam int WEIGHT_W = 32;
    localparam int SCORE_W  = 48;
    localparam int RATE_W   = 16;

    // q16.16 one, q0.16 rate constants (0.2, 0.01, 0.002)
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_ONE = 32'sd65536;
    localparam logic [RATE_W-1:0]          RATE_INIT  = 16'd13107;
    localparam logic [RATE_W-1:0]          RATE_FLOOR = 16'd655;
    localparam logic [RATE_W-1:0]          RATE_STEP  = 16'd131;

    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef logic signed [SCORE_W-1:0]  score_t;
    typedef logic [RATE_W-1:0]          rate_t;

    // control from the request stage to the state update
    typedef struct packed {
        logic   fire;
        logic   train;
        logic   expected;
        logic   pred;
        score_t score;
    } opc_upd_t;

endpackage

@@ sv/opc_in_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// opc_in_if
// Request channel: command, expected label and the feature vector.
// ============================================================================
interface opc_in_if #(
    parameter int FEATURE_BITS = opc_pkg::FEATURE_BITS_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic                           cmd;
    logic                           expected;
    logic signed [FEATURE_BITS-1:0] feature_0;
    logic signed [FEATURE_BITS-1:0] feature_1;
    logic signed [FEATURE_BITS-1:0] feature_2;
    logic signed [FEATURE_BITS-1:0] feature_3;
    logic signed [FEATURE_BITS-1:0] feature_4;
    logic signed [FEATURE_BITS-1:0] feature_5;
    logic signed [FEATURE_BITS-1:0] feature_6;
    logic signed [FEATURE_BITS-1:0] feature_7;

    modport source (
        output valid, cmd, expected,
        output feature_0, feature_1, feature_2, feature_3,
        output feature_4, feature_5, feature_6, feature_7,
        input  ready
    );
    modport sink (
        input  valid, cmd, expected,
        input  feature_0, feature_1, feature_2, feature_3,
        input  feature_4, feature_5, feature_6, feature_7,
        output ready
    );
endinterface

@@ sv/opc_out_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// opc_out_if
// Result channel: predicted class, correctness flag and score.
// ============================================================================
interface opc_out_if ();
    import opc_pkg::*;

    logic   valid;
    logic   ready;
    logic   predicted_class;
    logic   was_correct;
    score_t score;

    modport source (
        output valid, predicted_class, was_correct, score,
        input  ready
    );
    modport sink (
        input  valid, predicted_class, was_correct, score,
        output ready
    );
endinterface

@@ sv/opc_dot.sv @@
`timescale 1ns / 1ps
// ============================================================================
// opc_dot
// Dot product of weights and features, floor shift, threshold, saturation.
// ============================================================================
module opc_dot #(
    parameter int NUM_WEIGHTS  = opc_pkg::NUM_WEIGHTS_DEF,
    parameter int FEATURE_BITS = opc_pkg::FEATURE_BITS_DEF
) (
    input  opc_pkg::weight_t               weights [NUM_WEIGHTS],
    input  logic signed [FEATURE_BITS-1:0] feat    [NUM_WEIGHTS],
    input  opc_pkg::score_t                threshold,
    output opc_pkg::score_t                score
);
    import opc_pkg::*;

    localparam int FRAC   = FEATURE_BITS - 4;
    localparam int PROD_W = WEIGHT_W + FEATURE_BITS;
    localparam int ACC_W  = PROD_W + $clog2(NUM_WEIGHTS);
    localparam int SH_W   = ACC_W - FRAC;
    localparam int DIFF_W = ((SH_W > SCORE_W) ? SH_W : SCORE_W) + 1;

    logic signed [PROD_W-1:0] prod [NUM_WEIGHTS];
    logic signed [ACC_W-1:0]  acc;
    logic signed [SH_W-1:0]   acc_sh;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-SCORE_W:0]  top_bits;

    always_comb
    begin
        acc = '0;
        for (int i = 0; i < NUM_WEIGHTS; i++)
        begin
            prod[i] = PROD_W'(weights[i] * feat[i]);
            acc     = acc + ACC_W'(prod[i]);
        end
        // dropping the low bits of a two's complement value rounds to minus infinity
        acc_sh   = $signed(acc[ACC_W-1:FRAC]);
        diff     = DIFF_W'(acc_sh) - DIFF_W'(threshold);
        top_bits = diff[DIFF_W-1:SCORE_W-1];
        if ((&top_bits) || !(|top_bits))
        begin
            score = diff[SCORE_W-1:0];
        end
        else if (diff[DIFF_W-1])
        begin
            score = {1'b1, {(SCORE_W-1){1'b0}}};
        end
        else
        begin
            score = {1'b0, {(SCORE_W-1){1'b1}}};
        end
    end

endmodule

@@ sv/opc_update.sv @@
`timescale 1ns / 1ps
// ============================================================================
// opc_update
// Weight, threshold and learning rate registers with the training update.
// ============================================================================
module opc_update #(
    parameter int NUM_WEIGHTS  = opc_pkg::NUM_WEIGHTS_DEF,
    parameter int FEATURE_BITS = opc_pkg::FEATURE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  opc_pkg::opc_upd_t              upd,
    input  logic signed [FEATURE_BITS-1:0] feat    [NUM_WEIGHTS],
    output opc_pkg::weight_t               weights [NUM_WEIGHTS],
    output opc_pkg::score_t                threshold
);
    import opc_pkg::*;

    localparam int FRAC   = FEATURE_BITS - 4;
    localparam int PROD_W = RATE_W + 1 + FEATURE_BITS;
    localparam int STEP_W = PROD_W - FRAC;
    localparam int SUM_W  = WEIGHT_W + 1;

    weight_t weight_reg [NUM_WEIGHTS];
    weight_t weight_next [NUM_WEIGHTS];
    score_t  thr_reg;
    score_t  thr_next;
    rate_t   rate_reg;
    rate_t   rate_next;

    logic                     miss;
    logic signed [SCORE_W:0]  thr_sum;
    logic signed [PROD_W-1:0] step_prod [NUM_WEIGHTS];
    logic signed [STEP_W-1:0] step [NUM_WEIGHTS];
    logic signed [SUM_W-1:0]  wsum [NUM_WEIGHTS];

    always_comb
    begin
        miss      = upd.train && (upd.pred != upd.expected);
        rate_next = rate_reg;
        if (upd.fire && upd.train && (rate_reg > RATE_FLOOR))
        begin
            rate_next = rate_reg - RATE_STEP;
        end

        // threshold moves on a missed positive only if it stays non-negative
        thr_sum  = (SCORE_W+1)'(thr_reg) + (SCORE_W+1)'(upd.score);
        thr_next = thr_reg;
        if (upd.fire && miss && upd.expected && !thr_sum[SCORE_W])
        begin
            thr_next = thr_sum[SCORE_W-1:0];
        end

        for (int i = 0; i < NUM_WEIGHTS; i++)
        begin
            step_prod[i] = PROD_W'($signed({1'b0, rate_next}) * feat[i]);
            step[i]      = $signed(step_prod[i][PROD_W-1:FRAC]);
            if (upd.expected)
            begin
                wsum[i] = SUM_W'(weight_reg[i]) + SUM_W'(step[i]);
            end
            else
            begin
                wsum[i] = SUM_W'(weight_reg[i]) - SUM_W'(step[i]);
            end
            weight_next[i] = weight_reg[i];
            if (upd.fire && miss)
            begin
                if (wsum[i][SUM_W-1] == wsum[i][SUM_W-2])
                begin
                    weight_next[i] = wsum[i][WEIGHT_W-1:0];
                end
                else if (wsum[i][SUM_W-1])
                begin
                    weight_next[i] = {1'b1, {(WEIGHT_W-1){1'b0}}};
                end
                else
                begin
                    weight_next[i] = {1'b0, {(WEIGHT_W-1){1'b1}}};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= '0;
            rate_reg <= RATE_INIT;
            for (int i = 0; i < NUM_WEIGHTS; i++)
            begin
                weight_reg[i] <= WEIGHT_ONE;
            end
        end
        else
        begin
            thr_reg  <= thr_next;
            rate_reg <= rate_next;
            for (int i = 0; i < NUM_WEIGHTS; i++)
            begin
                weight_reg[i] <= weight_next[i];
            end
        end
    end

    assign weights   = weight_reg;
    assign threshold = thr_reg;

endmodule

@@ sv/online_perceptron_classifier.sv @@
`timescale 1ns / 1ps
// ============================================================================
// online_perceptron_classifier
// Perceptron with adaptive threshold: classifies or trains on each request.
// ============================================================================
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+----------------------------------------
//   sample   | in  | valid / ready | cmd, expected, feature_0 .. feature_7
//   result   | out | valid / ready | predicted_class, was_correct, score
//
// a request is registered on acceptance; once the result register can take
// its output the dot product, threshold compare and training update run in one
// pass and the result register, weights, threshold and rate load together, so
// the next request already sees the updated state
// the result is registered by the pass; one request per cycle is sustained
// through the single pass while the result side is ready
// reset (rst_n low) clears both valid flags, sets the weights to 1.0, the
// threshold to zero and the learning rate to 0.2
// a stalled result holds; the request stage accepts while it is empty or its
// contents move to the result register in the same cycle
//
module online_perceptron_classifier #(
    parameter int NUM_WEIGHTS  = opc_pkg::NUM_WEIGHTS_DEF,
    parameter int FEATURE_BITS = opc_pkg::FEATURE_BITS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    opc_in_if.sink   sample,
    opc_out_if.source result
);
    import opc_pkg::*;

    // request stage
    logic                           stage_valid_reg;
    logic                           stage_valid_next;
    logic                           stage_cmd_reg;
    logic                           stage_exp_reg;
    logic signed [FEATURE_BITS-1:0] feat_reg [NUM_WEIGHTS];
    logic signed [FEATURE_BITS-1:0] feat_in  [MAX_FEATURES];

    // result stage
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_pred_reg;
    logic   out_correct_reg;
    score_t out_score_reg;

    logic     accept;
    logic     fire;
    logic     pred;
    score_t   score;
    score_t   threshold;
    weight_t  weights [NUM_WEIGHTS];
    opc_upd_t upd;

    // the pass runs when the result register can take its output
    assign fire         = stage_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !stage_valid_reg || fire;
    assign accept       = sample.valid && sample.ready;

    always_comb
    begin
        feat_in[0] = sample.feature_0;
        feat_in[1] = sample.feature_1;
        feat_in[2] = sample.feature_2;
        feat_in[3] = sample.feature_3;
        feat_in[4] = sample.feature_4;
        feat_in[5] = sample.feature_5;
        feat_in[6] = sample.feature_6;
        feat_in[7] = sample.feature_7;
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (fire)
        begin
            stage_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // request payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_cmd_reg <= sample.cmd;
            stage_exp_reg <= sample.expected;
            for (int i = 0; i < NUM_WEIGHTS; i++)
            begin
                feat_reg[i] <= feat_in[i];
            end
        end
    end

    opc_dot #(
        .NUM_WEIGHTS  (NUM_WEIGHTS),
        .FEATURE_BITS (FEATURE_BITS)
    ) u_dot (
        .weights   (weights),
        .feat      (feat_reg),
        .threshold (threshold),
        .score     (score)
    );

    assign pred = !score[SCORE_W-1];

    always_comb
    begin
        upd.fire     = fire;
        upd.train    = stage_cmd_reg;
        upd.expected = stage_exp_reg;
        upd.pred     = pred;
        upd.score    = score;
    end

    opc_update #(
        .NUM_WEIGHTS  (NUM_WEIGHTS),
        .FEATURE_BITS (FEATURE_BITS)
    ) u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (upd),
        .feat      (feat_reg),
        .weights   (weights),
        .threshold (threshold)
    );

    // result payload, score taken before the state update
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_pred_reg    <= pred;
            out_correct_reg <= stage_cmd_reg && (pred == stage_exp_reg);
            out_score_reg   <= score;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.predicted_class = out_pred_reg;
    assign result.was_correct     = out_correct_reg;
    assign result.score           = out_score_reg;

`ifndef SYNTHESIS
    // threshold only ever moves to a non-negative value
    a_thr_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        !threshold[SCORE_W-1])
        else $error("adaptive threshold went negative");

    // a classify request leaves the threshold alone
    a_classify_keeps_thr: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !stage_cmd_reg) |=> $stable(threshold))
        else $error("threshold changed on a classify request");

    // a finished pass always shows up on the result channel
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> result.valid)
        else $error("pass completed without a result");

    // back pressure on the request side only when both stages are full
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (stage_valid_reg && out_valid_reg && !result.ready))
        else $error("request side stalled with room available");
`endif

endmodule
